[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define DRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define DRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/drd_pkg.sv]
package drd_pkg;

    localparam int VALUE_W           = 24;
    localparam int BOX_W             = VALUE_W - 1;
    localparam int CLASS_W           = 8;
    localparam int THR_W             = 13;
    localparam int NCLS_W            = 8;
    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 1;
    localparam int DEF_FRACTION_BITS = 12;
    localparam int DEF_MAX_CLASSES   = 255;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [THR_W-1:0]  RST_SCORE_FLOOR = THR_W'(1024);
    localparam logic [NCLS_W-1:0] RST_CLASS_COUNT = NCLS_W'(80);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_FLOOR = 1'b0,
        CFG_CLASS_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] left_x;
        logic signed [VALUE_W-1:0] top_y;
        logic        [BOX_W-1:0]   box_width;
        logic        [BOX_W-1:0]   box_height;
        logic        [CLASS_W-1:0] class_id;
        logic signed [VALUE_W-1:0] confidence;
    } t_out_item;

    // One finished record that passed the objectness and size checks.
    typedef struct packed {
        logic signed [VALUE_W-1:0] centre_x;
        logic signed [VALUE_W-1:0] centre_y;
        logic signed [VALUE_W-1:0] width;
        logic signed [VALUE_W-1:0] height;
        logic signed [VALUE_W-1:0] objectness;
        logic signed [VALUE_W-1:0] best_score;
        logic        [CLASS_W-1:0] best_index;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/drd_front.sv]
module drd_front
    import drd_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    input  logic [THR_W-1:0]   i_score_floor,
    input  logic [NCLS_W-1:0]  i_class_count,
    input  t_q_stat            i_q_stat,
    output logic               o_in_stall,
    output logic               o_push,
    output t_rec               o_push_rec
);

    localparam int POS_W = $clog2(MAX_CLASSES + 6);
    localparam int NC_W  = (POS_W > NCLS_W) ? POS_W : NCLS_W;

    logic [POS_W-1:0]          r_pos, n_pos;
    logic signed [VALUE_W-1:0] r_cx, n_cx;
    logic signed [VALUE_W-1:0] r_cy, n_cy;
    logic signed [VALUE_W-1:0] r_w, n_w;
    logic signed [VALUE_W-1:0] r_h, n_h;
    logic signed [VALUE_W-1:0] r_obj, n_obj;
    logic signed [VALUE_W-1:0] r_best, n_best;
    logic [CLASS_W-1:0]        r_idx, n_idx;

    logic                      accept;
    logic [NC_W-1:0]           nc_eff;
    logic [POS_W-1:0]          last_pos;
    logic [POS_W-1:0]          pos;
    logic [NC_W-1:0]           class_off;
    logic                      rec_end;
    logic                      box_ok;
    logic signed [VALUE_W-1:0] thr_s;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign thr_s      = $signed({{(VALUE_W-THR_W){1'b0}}, i_score_floor});

    always_comb begin
        nc_eff = NC_W'(i_class_count);
        if (nc_eff == '0) begin
            nc_eff = NC_W'(1);
        end else if (nc_eff > NC_W'(MAX_CLASSES)) begin
            nc_eff = NC_W'(MAX_CLASSES);
        end
    end

    assign last_pos  = POS_W'(nc_eff) + POS_W'(4);
    assign pos       = i_in_data.frame_start ? '0 : r_pos;
    assign class_off = NC_W'(pos) - NC_W'(5);
    assign rec_end   = (pos >= last_pos);

    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_w    = r_w;
        n_h    = r_h;
        n_obj  = r_obj;
        n_best = r_best;
        n_idx  = r_idx;
        n_pos  = r_pos;
        if (accept) begin
            if (pos == POS_W'(0)) begin
                n_cx = i_in_data.value;
            end else if (pos == POS_W'(1)) begin
                n_cy = i_in_data.value;
            end else if (pos == POS_W'(2)) begin
                n_w = i_in_data.value;
            end else if (pos == POS_W'(3)) begin
                n_h = i_in_data.value;
            end else if (pos == POS_W'(4)) begin
                n_obj = i_in_data.value;
            end else if (pos == POS_W'(5)) begin
                // first class score loads unconditionally
                n_best = i_in_data.value;
                n_idx  = '0;
            end else if (i_in_data.value > r_best) begin
                n_best = i_in_data.value;
                n_idx  = class_off[CLASS_W-1:0];
            end
            n_pos = rec_end ? '0 : pos + POS_W'(1);
        end
    end

    assign box_ok = (r_obj >= thr_s) && (r_w > 0) && (r_h > 0);
    assign o_push = accept && rec_end && box_ok;

    always_comb begin
        o_push_rec.centre_x   = r_cx;
        o_push_rec.centre_y   = r_cy;
        o_push_rec.width      = r_w;
        o_push_rec.height     = r_h;
        o_push_rec.objectness = r_obj;
        o_push_rec.best_score = n_best;
        o_push_rec.best_index = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_w    <= '0;
            r_h    <= '0;
            r_obj  <= '0;
            r_best <= {1'b1, {(VALUE_W-1){1'b0}}};
            r_idx  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_w    <= n_w;
            r_h    <= n_h;
            r_obj  <= n_obj;
            r_best <= n_best;
            r_idx  <= n_idx;
        end
    end

endmodule

[rtl/drd_queue.sv]
module drd_queue
    import drd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_rec    i_push_rec,
    input  logic    i_pop,
    output t_rec    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/drd_back.sv]
module drd_back
    import drd_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rec             i_head,
    input  t_q_stat          i_q_stat,
    input  logic [THR_W-1:0] i_score_floor,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    localparam int PROD_W = 2 * VALUE_W;

    localparam logic signed [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // stage A: product and box edges
    logic                      r_a_valid;
    logic signed [PROD_W-1:0]  r_a_prod;
    logic signed [VALUE_W-1:0] r_a_left;
    logic signed [VALUE_W-1:0] r_a_top;
    logic [BOX_W-1:0]          r_a_w;
    logic [BOX_W-1:0]          r_a_h;
    logic [CLASS_W-1:0]        r_a_idx;

    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      out_free;
    logic                      a_free;
    logic signed [PROD_W-1:0]  prod;
    logic signed [VALUE_W-1:0] left_sat;
    logic signed [VALUE_W-1:0] top_sat;
    logic signed [PROD_W-1:0]  shifted;
    logic signed [VALUE_W-1:0] conf;
    logic                      conf_ok;

    function automatic logic signed [VALUE_W-1:0] edge_sat(
        input logic signed [VALUE_W-1:0] c,
        input logic signed [VALUE_W-1:0] s
    );
        logic signed [VALUE_W:0] d;
        d = {c[VALUE_W-1], c} - {s[VALUE_W-1], s >>> 1};
        if (d[VALUE_W] != d[VALUE_W-1]) begin
            edge_sat = d[VALUE_W] ? V_MIN : V_MAX;
        end else begin
            edge_sat = d[VALUE_W-1:0];
        end
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign a_free   = !r_a_valid || out_free;
    assign o_pop    = a_free && !i_q_stat.empty;

    assign prod     = i_head.objectness * i_head.best_score;
    assign left_sat = edge_sat(i_head.centre_x, i_head.width);
    assign top_sat  = edge_sat(i_head.centre_y, i_head.height);

    // floor shift, then clamp to the value range
    assign shifted = r_a_prod >>> FRACTION_BITS;
    always_comb begin
        if (&shifted[PROD_W-1:VALUE_W-1] || !(|shifted[PROD_W-1:VALUE_W-1])) begin
            conf = shifted[VALUE_W-1:0];
        end else begin
            conf = shifted[PROD_W-1] ? V_MIN : V_MAX;
        end
    end
    assign conf_ok = conf >= $signed({{(VALUE_W-THR_W){1'b0}}, i_score_floor});

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_prod <= prod;
            r_a_left <= left_sat;
            r_a_top  <= top_sat;
            r_a_w    <= i_head.width[BOX_W-1:0];
            r_a_h    <= i_head.height[BOX_W-1:0];
            r_a_idx  <= i_head.best_index;
        end
        if (r_a_valid && out_free) begin
            r_out.left_x     <= r_a_left;
            r_out.top_y      <= r_a_top;
            r_out.box_width  <= r_a_w;
            r_out.box_height <= r_a_h;
            r_out.class_id   <= r_a_idx;
            r_out.confidence <= conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= !i_q_stat.empty;
            end
            if (out_free) begin
                r_out_valid <= r_a_valid && conf_ok;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/detection_record_decoder_top.sv]
// Detection record decoder. Takes one detector output value per transfer; each record is
// centre x, centre y, width, height, objectness and then the configured number of class
// scores, and a frame_start value restarts the record at centre x. The front end tracks the
// record position and a running argmax over the class scores at one value per cycle; at the
// last score a record with objectness at or above the score floor and positive width and
// height enters a four-entry queue. The back end multiplies objectness by the best score,
// floors and saturates the product, and delivers a corner box when the confidence also
// clears the floor. Input is taken every cycle unless the queue is full; a result passes from
// the queue through stage A to the output register, and one result per cycle can leave the
// output register while the output is not stalled. Configuration may be written only while no
// record is in flight.
module detection_record_decoder_top
    import drd_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int MAX_CLASSES   = DEF_MAX_CLASSES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [THR_W-1:0]  r_score_floor;
    logic [NCLS_W-1:0] r_class_count;

    t_q_stat q_stat;
    t_rec    push_rec;
    t_rec    head;
    logic    push;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_floor <= RST_SCORE_FLOOR;
            r_class_count <= RST_CLASS_COUNT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCORE_FLOOR: r_score_floor <= i_cfg_data[THR_W-1:0];
                CFG_CLASS_COUNT: r_class_count <= i_cfg_data[NCLS_W-1:0];
            endcase
        end
    end

    drd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_score_floor(r_score_floor),
        .i_class_count(r_class_count),
        .i_q_stat     (q_stat),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_rec   (push_rec)
    );

    drd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_rec(push_rec),
        .i_pop     (pop),
        .o_head    (head),
        .o_stat    (q_stat)
    );

    drd_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .i_score_floor(r_score_floor),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

[rtl/drd_checker.sv]
`include "assert_macros.svh"

module drd_checker
    import drd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input t_in_item             i_in_data,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input t_out_item            o_out_data,
    input logic                 i_out_stall,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data
);

    `DRD_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")
    `DRD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "valid dropped")
    `DRD_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_out_data), "payload moved")
    `DRD_ASSERT(a_box_positive, i_clk, i_rst_n, o_out_valid |-> o_out_data.box_width != '0 && o_out_data.box_height != '0, "empty box")
    `DRD_ASSERT(a_conf_nonneg, i_clk, i_rst_n, o_out_valid |-> !o_out_data.confidence[VALUE_W-1], "negative confidence")

endmodule

bind detection_record_decoder_top drd_checker u_drd_checker (.*);

[tb/detection_record_decoder_top_tb.sv]
`timescale 1ns / 1ps

module detection_record_decoder_top_tb;
    import drd_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int PHASE_ITEMS    = 130;
    localparam longint VAL_MAX    = (longint'(1) <<< (VALUE_W - 1)) - 1;
    localparam longint VAL_MIN    = -VAL_MAX - 1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    detection_record_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decoder state as seen by the predictor
    logic [THR_W-1:0]  thr_reg  = RST_SCORE_FLOOR;
    logic [NCLS_W-1:0] ncls_reg = RST_CLASS_COUNT;
    int                rec_pos  = 0;
    longint            cx = 0, cy = 0, bw = 0, bh = 0, obj = 0;
    longint            best     = VAL_MIN;
    logic [CLASS_W-1:0] best_cls = '0;

    t_in_item  pending[$];
    t_out_item expected_boxes[$];
    int        errors   = 0;
    int        sent     = 0;
    int        tx_mode  = 0;
    int        rx_mode  = 0;
    int        tx_gap   = 0;
    int        rx_wait  = 0;
    int        rx_next;
    int        quiet    = 0;

    function automatic longint clamp(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    function automatic longint any_value();
        return longint'($signed(VALUE_W'($urandom)));
    endfunction

    function automatic int draw_wait(input int mode);
        if (mode == 0) return 0;
        if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        return $urandom_range(0, 13);
    endfunction

    // one value into the record tracker; queues a box when a record closes and passes
    function automatic void decode_value(input t_in_item it);
        longint    v;
        longint    thr;
        longint    conf;
        int        last;
        t_out_item box;
        v    = longint'($signed(it.value));
        thr  = longint'(thr_reg);
        last = 4 + ((ncls_reg == 0) ? 1 : int'(ncls_reg));
        if (it.frame_start) rec_pos = 0;
        case (rec_pos)
            0: cx = v;
            1: cy = v;
            2: bw = v;
            3: bh = v;
            4: obj = v;
            5: begin
                best     = v;
                best_cls = '0;
            end
            default: begin
                if (v > best) begin
                    best     = v;
                    best_cls = CLASS_W'(rec_pos - 5);
                end
            end
        endcase
        if (rec_pos < last) begin
            rec_pos++;
            return;
        end
        rec_pos = 0;
        if (obj < thr || bw <= 0 || bh <= 0) return;
        conf = clamp((obj * best) >>> DEF_FRACTION_BITS);
        if (conf < thr) return;
        box.left_x     = VALUE_W'(clamp(cx - (bw >>> 1)));
        box.top_y      = VALUE_W'(clamp(cy - (bh >>> 1)));
        box.box_width  = BOX_W'(bw);
        box.box_height = BOX_W'(bh);
        box.class_id   = best_cls;
        box.confidence = VALUE_W'(conf);
        expected_boxes.insert(expected_boxes.size(), box);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic check_box(input t_out_item got);
        t_out_item want;
        if (expected_boxes.size() == 0) begin
            report_mismatch($sformatf("box with none pending: %h", got));
            return;
        end
        want = expected_boxes.pop_front();
        if (got.left_x !== want.left_x)
            report_mismatch($sformatf("left_x %h, want %h", got.left_x, want.left_x));
        if (got.top_y !== want.top_y)
            report_mismatch($sformatf("top_y %h, want %h", got.top_y, want.top_y));
        if (got.box_width !== want.box_width)
            report_mismatch($sformatf("box_width %h, want %h", got.box_width, want.box_width));
        if (got.box_height !== want.box_height)
            report_mismatch($sformatf("box_height %h, want %h", got.box_height,
                                      want.box_height));
        if (got.class_id !== want.class_id)
            report_mismatch($sformatf("class_id %0d, want %0d", got.class_id, want.class_id));
        if (got.confidence !== want.confidence)
            report_mismatch($sformatf("confidence %h, want %h", got.confidence,
                                      want.confidence));
    endtask

    // sender: one transfer per item, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) decode_value(i_in_data);
            if (i_in_valid && o_in_stall) begin
                // hold payload until the transfer happens
            end else if (tx_gap != 0) begin
                i_in_valid <= 1'b0;
                tx_gap     <= tx_gap - 1;
            end else if (pending.size() != 0) begin
                i_in_data  <= pending.pop_front();
                i_in_valid <= 1'b1;
                tx_gap     <= draw_wait(tx_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer, then stalls a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait     <= 0;
        end else begin
            rx_next = rx_wait;
            if (o_out_valid && !i_out_stall) begin
                check_box(o_out_data);
                rx_next = draw_wait(rx_mode);
            end
            if (rx_next != 0) begin
                i_out_stall <= 1'b1;
                rx_wait     <= rx_next - 1;
            end else begin
                i_out_stall <= 1'b0;
                rx_wait     <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("detection_record_decoder_top_tb failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_val(input longint v, input bit fs);
        t_in_item it;
        it.value       = VALUE_W'(v);
        it.frame_start = fs;
        pending.insert(pending.size(), it);
        sent++;
    endtask

    // blocks the caller until every queued value is taken and every box is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending.size() != 0 || i_in_valid || expected_boxes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned data);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SCORE_FLOOR) thr_reg = THR_W'(data);
        else ncls_reg = NCLS_W'(data);
    endtask

    // one record with random content; cut > 0 truncates it
    task automatic send_record(input bit fs, input int cut);
        longint v;
        longint score;
        int     ncls;
        int     n;
        ncls  = (ncls_reg == 0) ? 1 : int'(ncls_reg);
        n     = (cut > 0) ? cut : 5 + ncls;
        score = 0;
        for (int i = 0; i < n; i++) begin
            if (i < 2) begin
                if ($urandom_range(0, 7) == 0) v = any_value();
                else v = longint'($urandom_range(0, 2700000)) - 50000;
            end else if (i < 4) begin
                case ($urandom_range(0, 15))
                    0:       v = 0;
                    1:       v = -longint'($urandom_range(1, 100000));
                    2:       v = any_value();
                    3:       v = VAL_MAX;
                    default: v = $urandom_range(1, 1048576);
                endcase
            end else if (i == 4) begin
                case ($urandom_range(0, 7))
                    4:       v = $urandom_range(0, 8192);
                    5:       v = any_value();
                    6:       v = longint'(thr_reg);
                    7:       v = longint'(thr_reg) - 1;
                    default: v = longint'(thr_reg) + $urandom_range(0, 8192);
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    5:       v = any_value();
                    6:       v = -longint'($urandom_range(0, 8192));
                    7:       v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                    8:       v = (i > 5) ? score : 0;
                    default: v = $urandom_range(0, 8192);
                endcase
                score = v;
            end
            push_val(v, fs && i == 0);
        end
    endtask

    initial begin
        int unsigned ph_thr[6];
        int unsigned ph_ncls[6];
        int          phase;
        int          phase_start;
        int unsigned thr;
        int unsigned ncls;

        ph_thr  = '{1024, 0, 8191, 4096, 2000, 1024};
        ph_ncls = '{3, 1, 2, 0, 255, 80};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one class per record
        write_reg(CFG_SCORE_FLOOR, 1024);
        write_reg(CFG_CLASS_COUNT, 1);
        push_val(10000, 1); push_val(20000, 0); push_val(4096, 0);
        push_val(8192, 0);  push_val(4096, 0);  push_val(3000, 0);
        // edges saturate low, confidence saturates high
        push_val(VAL_MIN, 0); push_val(VAL_MIN, 0); push_val(VAL_MAX, 0);
        push_val(VAL_MAX, 0); push_val(VAL_MAX, 0); push_val(VAL_MAX, 0);
        // broken record, then frame start realigns; zero width drops it
        push_val(777, 0); push_val(888, 0);
        push_val(5, 1); push_val(5, 0); push_val(0, 0);
        push_val(100, 0); push_val(8191, 0); push_val(8191, 0);
        // class count lowered mid record: next value closes it
        write_reg(CFG_CLASS_COUNT, 3);
        push_val(0, 1); push_val(0, 0); push_val(4096, 0); push_val(4096, 0);
        push_val(4096, 0); push_val(100, 0); push_val(4000, 0);
        write_reg(CFG_CLASS_COUNT, 1);
        push_val(4000, 0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase < 6) begin
                thr  = ph_thr[phase];
                ncls = ph_ncls[phase];
            end else begin
                case ($urandom_range(0, 5))
                    0:       thr = 0;
                    1:       thr = 4096;
                    2:       thr = $urandom_range(0, 8191);
                    default: thr = $urandom_range(256, 3000);
                endcase
                ncls = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            end
            write_reg(CFG_SCORE_FLOOR, thr);
            write_reg(CFG_CLASS_COUNT, ncls);
            tx_mode     = $urandom_range(0, 2);
            rx_mode     = $urandom_range(0, 2);
            phase_start = sent;
            send_record(1'b1, 0);
            while (sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 15))
                    0: begin
                        // noise
                        repeat ($urandom_range(1, 6))
                            push_val(any_value(), 1'($urandom_range(0, 1)));
                        send_record(1'b1, 0);
                    end
                    1: begin
                        send_record(1'($urandom_range(0, 1)), int'($urandom_range(1, 5)));
                        send_record(1'b1, 0);
                    end
                    2: send_record(1'b1, 0);
                    default: send_record(1'b0, 0);
                endcase
                if ($urandom_range(0, 9) == 0) wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_boxes.size() != 0)
            report_mismatch($sformatf("%0d boxes never delivered", expected_boxes.size()));
        if (errors == 0) begin
            $display("detection_record_decoder_top_tb passed");
        end else begin
            $display("detection_record_decoder_top_tb failed");
        end
        $finish;
    end

endmodule

[detection_record_decoder_top.f]
+incdir+rtl
rtl/drd_pkg.sv
rtl/drd_front.sv
rtl/drd_queue.sv
rtl/drd_back.sv
rtl/detection_record_decoder_top.sv
rtl/drd_checker.sv
tb/detection_record_decoder_top_tb.sv
